// ===== rtl/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse unit.
`default_nettype none
package mi3_pkg;

	localparam int NENT    = 9;
	localparam int M_W     = 32;
	localparam int PROD_W  = 64;
	localparam int CM_W    = 64;
	localparam int PP_W    = 96;
	localparam int DET_W   = 97;
	localparam int DMAG_W  = 96;
	localparam int WIDE_W  = 130;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	localparam logic [M_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [M_W-1:0] SAT_NEG = 32'h8000_0000;

	// cofactor i = m[A]*m[B] - m[C]*m[D], adjugate row-major
	localparam logic [3:0] COF_A [NENT] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
	localparam logic [3:0] COF_B [NENT] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
	localparam logic [3:0] COF_C [NENT] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
	localparam logic [3:0] COF_D [NENT] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

	typedef logic [NENT-1:0][M_W-1:0] mat_t;

	typedef struct packed {
		logic                       sing;
		logic                       dneg;
		logic [DMAG_W-1:0]          dmag;
		logic [NENT-1:0]            cn;
		logic [NENT-1:0][CM_W-1:0]  cm;   // input entry, zero-extended, when sing
	} q_entry_t;

endpackage
`default_nettype wire

// ===== rtl/mi3_front.sv =====
// Front part: cofactors, determinant and singular classification.
`default_nettype none
module mi3_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  mi3_pkg::mat_t      in_m,
	output logic               out_valid,
	input  wire                out_ready,
	output mi3_pkg::q_entry_t  out_entry
);
	import mi3_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	mat_t m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7;
	logic signed [PROD_W-1:0] pab_s2 [NENT];
	logic signed [PROD_W-1:0] pcd_s2 [NENT];
	logic [NENT-1:0]             cn_s3, cn_s4, cn_s5, cn_s6, cn_s7;
	logic [NENT-1:0][CM_W-1:0]   cm_s3, cm_s4, cm_s5, cm_s6, cm_s7;
	logic [2:0][63:0]            pl_s4, ph_s4;
	logic [2:0]                  psg_s4, psg_s5;
	logic [2:0][PP_W-1:0]        p_s5;
	logic [2:0][DET_W-1:0]       ps_s6;
	logic [DET_W-1:0]            det_s7;

	logic [NENT-1:0]             cn_c;
	logic [NENT-1:0][CM_W-1:0]   cm_c;
	logic [2:0][63:0]            pl_c, ph_c;
	logic [2:0]                  psg_c;

	assign en        = !v_s7 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		logic signed [PROD_W:0] diff;
		cn_c = '0;
		cm_c = '0;
		for (int i = 0; i < NENT; i++) begin
			diff = {pab_s2[i][PROD_W-1], pab_s2[i]} - {pcd_s2[i][PROD_W-1], pcd_s2[i]};
			cn_c[i] = diff[PROD_W];
			cm_c[i] = diff[PROD_W] ? CM_W'(-diff) : diff[CM_W-1:0];
		end
	end

	always_comb begin
		logic [M_W-1:0] e;
		logic [M_W-1:0] emag;
		pl_c  = '0;
		ph_c  = '0;
		psg_c = '0;
		for (int j = 0; j < 3; j++) begin
			e        = m_s3[j];
			emag     = e[M_W-1] ? (~e + 32'd1) : e;
			pl_c[j]  = 64'(emag) * 64'(cm_s3[3*j][31:0]);
			ph_c[j]  = 64'(emag) * 64'(cm_s3[3*j][63:32]);
			psg_c[j] = e[M_W-1] ^ cn_s3[3*j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= in_m;
			for (int i = 0; i < NENT; i++) begin
				pab_s2[i] <= $signed(m_s1[COF_A[i]]) * $signed(m_s1[COF_B[i]]);
				pcd_s2[i] <= $signed(m_s1[COF_C[i]]) * $signed(m_s1[COF_D[i]]);
			end
			m_s2   <= m_s1;
			cn_s3  <= cn_c;
			cm_s3  <= cm_c;
			m_s3   <= m_s2;
			pl_s4  <= pl_c;
			ph_s4  <= ph_c;
			psg_s4 <= psg_c;
			cn_s4  <= cn_s3;
			cm_s4  <= cm_s3;
			m_s4   <= m_s3;
			for (int j = 0; j < 3; j++) begin
				p_s5[j] <= PP_W'(pl_s4[j]) + {ph_s4[j], 32'd0};
				ps_s6[j] <= psg_s5[j] ? -{1'b0, p_s5[j]} : {1'b0, p_s5[j]};
			end
			psg_s5 <= psg_s4;
			cn_s5  <= cn_s4;
			cm_s5  <= cm_s4;
			m_s5   <= m_s4;
			cn_s6  <= cn_s5;
			cm_s6  <= cm_s5;
			m_s6   <= m_s5;
			det_s7 <= ps_s6[0] + ps_s6[1] + ps_s6[2];
			cn_s7  <= cn_s6;
			cm_s7  <= cm_s6;
			m_s7   <= m_s6;
		end
	end

	always_comb begin
		logic [DET_W-1:0] dn;
		dn = -det_s7;
		out_entry.sing = (det_s7 == '0);
		out_entry.dneg = det_s7[DET_W-1];
		out_entry.dmag = det_s7[DET_W-1] ? dn[DMAG_W-1:0] : det_s7[DMAG_W-1:0];
		out_entry.cn   = cn_s7;
		for (int i = 0; i < NENT; i++) begin
			out_entry.cm[i] = (det_s7 == '0) ? CM_W'(m_s7[i]) : cm_s7[i];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mi3_fifo.sv =====
// Short queue between the front and back parts.
`default_nettype none
module mi3_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	output logic               push_ready,
	input  mi3_pkg::q_entry_t  push_entry,
	output logic               pop_valid,
	input  wire                pop_ready,
	output mi3_pkg::q_entry_t  pop_entry
);
	import mi3_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count above depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + QCNT_W'($past(push)) - QCNT_W'($past(pop)))
		else $error("queue count mismatch");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCNT_W'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers inconsistent");
`endif

endmodule
`default_nettype wire

// ===== rtl/mi3_back.sv =====
// Back part: pipelined restoring division, rounding and saturation.
`default_nettype none
module mi3_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  mi3_pkg::q_entry_t  in_entry,
	output logic               out_valid,
	input  wire                out_ready,
	output mi3_pkg::mat_t      out_inv,
	output logic               out_sing
);
	import mi3_pkg::*;

	localparam int SH    = 2 * FRAC_BITS;
	localparam int NSTG  = 33;

	typedef struct packed {
		logic [WIDE_W-1:0] r;
		logic [M_W-1:0]    q;
		logic              ovf;
		logic              neg;
	} lane_t;

	typedef struct packed {
		logic                    sing;
		logic [DMAG_W-1:0]       d;
		logic [NENT-1:0] [$bits(lane_t)-1:0] ln;
	} stage_t;

	logic   en;
	logic   vld_s [NSTG];
	stage_t pipe_s [NSTG];
	stage_t st0_c;
	mat_t   inv_c;
	logic   out_valid_q;
	logic   out_sing_q;
	mat_t   out_inv_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_inv   = out_inv_q;
	assign out_sing  = out_sing_q;

	always_comb begin
		lane_t             l;
		logic [WIDE_W-1:0] num;
		logic [WIDE_W-1:0] dsh;
		st0_c.sing = in_entry.sing;
		st0_c.d    = in_entry.dmag;
		for (int i = 0; i < NENT; i++) begin
			num   = WIDE_W'(in_entry.cm[i]) << SH;
			dsh   = WIDE_W'(in_entry.dmag) << M_W;
			l.r   = num;
			l.q   = in_entry.sing ? in_entry.cm[i][M_W-1:0] : '0;
			l.ovf = !in_entry.sing && (num >= dsh);
			l.neg = in_entry.cn[i] ^ in_entry.dneg;
			st0_c.ln[i] = l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) pipe_s[0] <= st0_c;
	end

	for (genvar j = 1; j < NSTG; j++) begin : g_div
		localparam int BIT = NSTG - 1 - j;
		stage_t nxt_c;

		always_comb begin
			lane_t             l;
			logic [WIDE_W-1:0] ds;
			nxt_c = pipe_s[j-1];
			ds    = WIDE_W'(pipe_s[j-1].d) << BIT;
			for (int i = 0; i < NENT; i++) begin
				l = pipe_s[j-1].ln[i];
				if (!pipe_s[j-1].sing && !l.ovf && (l.r >= ds)) begin
					l.r      = l.r - ds;
					l.q[BIT] = 1'b1;
				end
				nxt_c.ln[i] = l;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) pipe_s[j] <= nxt_c;
		end
	end

	always_comb begin
		lane_t          l;
		logic           inc;
		logic [M_W:0]   q33;
		logic [M_W:0]   qn;
		for (int i = 0; i < NENT; i++) begin
			l   = pipe_s[NSTG-1].ln[i];
			inc = ({l.r[DMAG_W-1:0], 1'b0} >= {1'b0, pipe_s[NSTG-1].d});
			q33 = {1'b0, l.q} + (M_W+1)'(inc);
			qn  = -q33;
			if (pipe_s[NSTG-1].sing) begin
				inv_c[i] = l.q;
			end else if (l.neg) begin
				inv_c[i] = (l.ovf || q33 > (M_W+1)'(SAT_NEG)) ? SAT_NEG : qn[M_W-1:0];
			end else begin
				inv_c[i] = (l.ovf || q33 > (M_W+1)'(SAT_POS)) ? SAT_POS : q33[M_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_inv_q  <= inv_c;
			out_sing_q <= pipe_s[NSTG-1].sing;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/matrix3x3_inverse_unit.sv =====
// Top level of the 3x3 matrix inverse unit.
// Input stream s_axis: one 3x3 matrix per item, nine signed fixed-point entries.
// Output stream m_axis: the nine inverse entries, plus a singular flag in tuser.
// The front part forms cofactors and the determinant in seven register stages,
// then writes a four-entry queue. The back part runs a 34-stage pipeline: one
// overflow check, one quotient bit per stage over 32 stages for all nine
// entries, then rounding, saturation and the output register.
// Throughput is one item per cycle while m_axis_tready is high and nothing stalls;
// the division pipeline sets the latency.
// A zero determinant returns the input entries unchanged with tuser set.
// When m_axis_tready is low the back pipeline holds, the queue fills, and
// then the front pipeline holds and s_axis_tready drops.
// Reset clears all valid flags and the queue; nothing else needs clearing.
`default_nettype none
module matrix3x3_inverse_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_axis_tvalid,
	output logic          s_axis_tready,
	input  wire  [287:0]  s_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic          m_axis_tvalid,
	input  wire           m_axis_tready,
	output logic [287:0]  m_axis_tdata,   // inv00, inv01, inv02, inv10 .. inv22
	output logic          m_axis_tuser    // singular
);
	import mi3_pkg::*;

	mat_t     in_m;
	mat_t     out_inv;
	q_entry_t f_entry, b_entry;
	logic     f_valid, f_ready, b_valid, b_ready;

	assign in_m         = s_axis_tdata;
	assign m_axis_tdata = out_inv;

	mi3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_m      (in_m),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_entry (f_entry)
	);

	mi3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_entry (f_entry),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_entry  (b_entry)
	);

	mi3_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_entry  (b_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_inv   (out_inv),
		.out_sing  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ===== sim/matrix3x3_inverse_unit_checker.sv =====
// Checker for the 3x3 matrix inverse unit: predicts each inverse and compares.
`default_nettype none
module matrix3x3_inverse_unit_checker #(
	parameter int FRAC_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	input  wire          s_axis_tready,
	input  wire  [287:0] s_axis_tdata,
	input  wire          m_axis_tvalid,
	input  wire          m_axis_tready,
	input  wire  [287:0] m_axis_tdata,
	input  wire          m_axis_tuser,
	output int           errors,
	output int           pending,
	output int           n_checked,
	output int           n_singular
);
	import mi3_pkg::*;

	typedef struct {
		logic [287:0] ent;
		logic         sing;
	} inv_t;

	inv_t inv_q[$];

	function automatic logic signed [65:0] minor2(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d);
		logic signed [65:0] p, r;
		p = 66'(a) * 66'(b);
		r = 66'(c) * 66'(d);
		return p - r;
	endfunction

	function automatic inv_t invert(logic [287:0] din);
		logic signed [31:0]  m [9];
		logic signed [65:0]  adj [9];
		logic signed [127:0] det;
		logic [127:0]        dmag, num, q, rem;
		logic [127:0]        amag;
		logic                neg;
		inv_t                r;
		for (int i = 0; i < 9; i++)
			m[i] = din[32*i +: 32];
		adj[0] = minor2(m[4], m[8], m[7], m[5]);
		adj[1] = minor2(m[7], m[2], m[1], m[8]);
		adj[2] = minor2(m[1], m[5], m[4], m[2]);
		adj[3] = minor2(m[6], m[5], m[3], m[8]);
		adj[4] = minor2(m[0], m[8], m[6], m[2]);
		adj[5] = minor2(m[3], m[2], m[0], m[5]);
		adj[6] = minor2(m[3], m[7], m[6], m[4]);
		adj[7] = minor2(m[6], m[1], m[0], m[7]);
		adj[8] = minor2(m[0], m[4], m[3], m[1]);
		det = 128'(m[0]) * 128'(adj[0]) + 128'(m[1]) * 128'(adj[3])
			+ 128'(m[2]) * 128'(adj[6]);
		r.ent = din;
		r.sing = (det == 0);
		if (r.sing)
			return r;
		dmag = det[127] ? -det : det;
		for (int i = 0; i < 9; i++) begin
			amag = adj[i][65] ? 128'(-adj[i]) : 128'(adj[i]);
			neg = adj[i][65] ^ det[127];
			num = amag << (2 * FRAC_BITS);
			q = num / dmag;
			rem = num % dmag;
			if ((rem << 1) >= dmag)
				q = q + 1;
			if (neg)
				r.ent[32*i +: 32] = (q > 128'h8000_0000) ? SAT_NEG : 32'(-q);
			else
				r.ent[32*i +: 32] = (q > 128'h7FFF_FFFF) ? SAT_POS : q[31:0];
		end
		return r;
	endfunction

	task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
		$display("mismatch %0s[%0d] item %0d: got %h want %h", what, idx, n_checked, got, want);
		errors++;
	endtask

	assign pending = inv_q.size();

	always @(posedge clk) begin
		inv_t w;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			inv_q.push_back(invert(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (inv_q.size() == 0) begin
				report("unexpected", 0, m_axis_tdata[31:0], '0);
			end else begin
				w = inv_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (m_axis_tdata[32*i +: 32] !== w.ent[32*i +: 32])
						report("inv", i, m_axis_tdata[32*i +: 32], w.ent[32*i +: 32]);
				if (m_axis_tuser !== w.sing)
					report("singular", 0, 32'(m_axis_tuser), 32'(w.sing));
				if (w.sing)
					n_singular++;
				n_checked++;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sim/matrix3x3_inverse_unit_tb.sv =====
// Testbench top for the 3x3 matrix inverse unit: stimulus, stalls and verdict.
`default_nettype none
module matrix3x3_inverse_unit_tb;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic [287:0] s_axis_tdata = '0;
	logic         m_axis_tready = 0;
	wire          s_axis_tready, m_axis_tvalid, m_axis_tuser;
	wire  [287:0] m_axis_tdata;
	int           errors, pending, n_checked, n_singular;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	matrix3x3_inverse_unit u_top (.*);

	matrix3x3_inverse_unit_checker u_chk (.*);

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
			3: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			4: return 32'($urandom_range(0, 3)) - 32'd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [287:0] rand_matrix();
		logic [287:0] d;
		int k;
		for (int i = 0; i < 9; i++)
			d[32*i +: 32] = rand_entry();
		k = $urandom_range(0, 7);
		if (k == 0)
			d[95:64] = d[31:0];
		if (k == 1) begin
			d[127:96] = d[31:0];
			d[159:128] = d[63:32];
			d[191:160] = d[95:64];
		end
		if (k == 2)
			d[287:192] = '0;
		return d;
	endfunction

	task automatic send(logic [287:0] d);
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic gap();
		s_axis_tvalid <= 0;
		s_axis_tdata <= '0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic logic [287:0] diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		logic [287:0] d = '0;
		d[31:0] = a;
		d[159:128] = b;
		d[287:256] = c;
		return d;
	endfunction

	always @(posedge clk) begin
		int cnt;
		if (cnt == 0)
			cnt = $urandom_range(1, 40);
		cnt--;
		case ((cnt / 10) % 4)
			0: m_axis_tready <= 1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= cnt[0];
		endcase
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int burst;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		send(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
		send(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send(diag(32'd1, 32'd1, 32'd1));
		send(diag(32'hFFFF_FFFF, 32'd1, 32'd1));
		send('0);
		send({9{32'hFFFF_FFFF}});
		send({9{32'h8000_0000}});
		send({9{32'h7FFF_FFFF}});
		send({9{32'h5555_AAAA}});
		send({$urandom(), $urandom(), $urandom(), 192'd0});
		send({32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
			32'h0, 32'h0, 32'h0001_0000});
		send(diag(32'h0100_0000, 32'h0100_0000, 32'h0000_0001));
		send(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
		gap();
		wait (pending == 0);
		for (int n = 0; n < 450; ) begin
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst && n < 450; b++, n++)
				send(rand_matrix());
			if ($urandom_range(0, 2) == 0)
				gap();
			if (n > 200 && n < 235) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
				wait (pending == 0);
			end
		end
		s_axis_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("checked %0d inverses, %0d of them singular, under bursty input and output stalls",
			n_checked, n_singular);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
